FILE: rtl/packed_track_cell_decoder_unit_assert.svh
// Assertion macros for the packed track cell decoder.
`ifndef PACKED_TRACK_CELL_DECODER_UNIT_ASSERT_SVH
`define PACKED_TRACK_CELL_DECODER_UNIT_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define PTCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a result in the next.
`define PTCD_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expr)) else $error(msg);

`endif

FILE: rtl/ptcd_pkg.sv
// Types, constants and helper functions of the packed track cell decoder.
package ptcd_pkg;

    localparam int ROWS_PER_TRACK = 64;
    localparam int ROW_W          = $clog2(ROWS_PER_TRACK + 1);

    localparam logic [ROW_W-1:0] ROWS_VAL = ROW_W'(ROWS_PER_TRACK);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS_PER_TRACK - 1);

    localparam logic [1:0] TOP_SKIP   = 2'b11;
    localparam logic [1:0] TOP_EFFECT = 2'b10;
    localparam logic [8:0] SKIP_BASE  = 9'h100;
    localparam logic [5:0] MAX_NOTE   = 6'd36;

    localparam logic [3:0] FX_SLIDE_UP = 4'h5;
    localparam logic [3:0] FX_SLIDE_DN = 4'h6;
    localparam logic [3:0] FX_VOL_SLD  = 4'hA;
    localparam logic [3:0] FX_UNUSED   = 4'h8;
    localparam logic [3:0] FX_NONE     = 4'h0;
    localparam logic [7:0] PRM_HALF    = 8'h80;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_BYTE2 = 3'b010,
        PH_BYTE3 = 3'b100
    } t_phase;

    typedef struct packed {
        t_phase           phase;
        logic [7:0]       first_byte;
        logic [7:0]       second_byte;
        logic [ROW_W-1:0] row_count;
    } t_dec_state;

    typedef struct packed {
        logic [5:0]  row_index;
        logic [11:0] period;
        logic [4:0]  instrument;
        logic [3:0]  effect;
        logic [7:0]  effect_param;
        logic        last_row;
        logic        bad_note;
    } t_cell;

    typedef struct packed {
        logic             emit;
        t_cell            row_cell;
        t_dec_state       state;
        logic [ROW_W-1:0] skip_left;
    } t_dec_result;

    function automatic logic [11:0] period_lookup(input logic [5:0] idx);
        logic [11:0] p;
        case (idx)
            6'd1:  p = 12'd856;  6'd2:  p = 12'd808;  6'd3:  p = 12'd762;
            6'd4:  p = 12'd720;  6'd5:  p = 12'd678;  6'd6:  p = 12'd640;
            6'd7:  p = 12'd604;  6'd8:  p = 12'd570;  6'd9:  p = 12'd538;
            6'd10: p = 12'd508;  6'd11: p = 12'd480;  6'd12: p = 12'd453;
            6'd13: p = 12'd428;  6'd14: p = 12'd404;  6'd15: p = 12'd381;
            6'd16: p = 12'd360;  6'd17: p = 12'd339;  6'd18: p = 12'd320;
            6'd19: p = 12'd302;  6'd20: p = 12'd285;  6'd21: p = 12'd269;
            6'd22: p = 12'd254;  6'd23: p = 12'd240;  6'd24: p = 12'd226;
            6'd25: p = 12'd214;  6'd26: p = 12'd202;  6'd27: p = 12'd190;
            6'd28: p = 12'd180;  6'd29: p = 12'd170;  6'd30: p = 12'd160;
            6'd31: p = 12'd151;  6'd32: p = 12'd143;  6'd33: p = 12'd135;
            6'd34: p = 12'd127;  6'd35: p = 12'd120;  6'd36: p = 12'd113;
            default: p = 12'd0;
        endcase
        return p;
    endfunction

    // Slide effects: large params are negated, small ones move up a nibble.
    function automatic logic [7:0] slide_fix(input logic [3:0] fx, input logic [7:0] p);
        logic [7:0] r;
        r = p;
        if (fx == FX_SLIDE_UP || fx == FX_SLIDE_DN || fx == FX_VOL_SLD) begin
            if (p > PRM_HALF) begin
                r = 8'(SKIP_BASE - {1'b0, p});
            end else begin
                r = {p[3:0], 4'h0};
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] fx_remap(input logic [3:0] fx);
        return (fx == FX_UNUSED) ? FX_NONE : fx;
    endfunction

    // Note cell without row fields.
    function automatic t_cell note_cell(input logic [7:0] c1, input logic [7:0] c2,
                                        input logic [3:0] fx, input logic [7:0] prm);
        t_cell      c;
        logic [5:0] idx;
        c            = '0;
        idx          = c1[6] ? ~c1[5:0] : c1[5:0];
        c.instrument = {c1[6], c2[7:4]};
        c.effect     = fx;
        c.effect_param = prm;
        if (idx > MAX_NOTE) begin
            c.bad_note = 1'b1;
        end else begin
            c.period = period_lookup(idx);
        end
        return c;
    endfunction

endpackage

FILE: rtl/ptcd_cell_decode.sv
// Token decoder: next decoder state and the cell for one byte or one skip row.
module ptcd_cell_decode import ptcd_pkg::*; (
    input  t_dec_state       i_state,
    input  logic [ROW_W-1:0] i_skip_left,
    input  logic             i_drain,
    input  logic [7:0]       i_byte,
    input  logic             i_start,
    output t_dec_result      o_res
);

    always_comb begin
        t_dec_result      res;
        logic [ROW_W-1:0] row;
        logic [8:0]       run_req;
        logic [8:0]       run_left;
        logic [8:0]       run;
        logic [3:0]       fx;

        res           = '0;
        res.state     = i_state;
        res.skip_left = i_skip_left;
        run_req       = SKIP_BASE - {1'b0, i_byte};
        run_left      = 9'(ROWS_VAL) - 9'(i_state.row_count);
        run           = '0;
        fx            = '0;
        row           = i_state.row_count;

        if (i_drain) begin
            // pending empty row of a skip run
            res.emit      = 1'b1;
            res.skip_left = i_skip_left - ROW_W'(1);
        end else begin
            if (i_start) begin
                row                 = '0;
                res.state.row_count = '0;
                res.state.phase     = PH_IDLE;
                run_left            = 9'(ROWS_VAL);
            end
            if (row < ROWS_VAL) begin
                unique case (res.state.phase)
                    PH_IDLE: begin
                        if (i_byte[7:6] == TOP_SKIP) begin
                            run           = (run_req > run_left) ? run_left : run_req;
                            res.emit      = 1'b1;
                            res.skip_left = ROW_W'(run - 9'd1);
                        end else begin
                            res.state.first_byte = i_byte;
                            res.state.phase      = PH_BYTE2;
                        end
                    end
                    PH_BYTE2: begin
                        res.state.second_byte = i_byte;
                        if (res.state.first_byte[7:6] == TOP_EFFECT) begin
                            fx                        = res.state.first_byte[4:1];
                            res.emit                  = 1'b1;
                            res.row_cell.effect       = fx_remap(fx);
                            res.row_cell.effect_param = slide_fix(fx, i_byte);
                            res.state.phase           = PH_IDLE;
                        end else if (i_byte[3:0] == FX_NONE) begin
                            res.emit        = 1'b1;
                            res.row_cell    = note_cell(res.state.first_byte, i_byte,
                                                        FX_NONE, 8'h00);
                            res.state.phase = PH_IDLE;
                        end else begin
                            res.state.phase = PH_BYTE3;
                        end
                    end
                    PH_BYTE3: begin
                        fx              = res.state.second_byte[3:0];
                        res.emit        = 1'b1;
                        res.row_cell    = note_cell(res.state.first_byte,
                                                    res.state.second_byte,
                                                    fx_remap(fx), slide_fix(fx, i_byte));
                        res.state.phase = PH_IDLE;
                    end
                    default: begin
                        res.state.phase = PH_IDLE;
                    end
                endcase
            end
        end

        if (res.emit) begin
            res.row_cell.row_index = 6'(row);
            res.row_cell.last_row  = (row == LAST_ROW);
            res.state.row_count    = row + ROW_W'(1);
        end
        o_res = res;
    end

endmodule

FILE: rtl/packed_track_cell_decoder_unit.sv
// Top level of the packed track cell decoder: input register, decoder, cell register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | sink      | i_in_valid / o_in_stall | i_data_byte, i_track_start
//  out     | source    | o_out_valid / i_out_stall | o_row_index, o_period, o_instrument,
//          |           |                        | o_effect, o_effect_param, o_last_row,
//          |           |                        | o_bad_note
//
// One byte request is taken per cycle while o_in_stall is low. A byte is
// registered in the input register, is decoded and, if it completes a token,
// lands in the cell register once the output is free and no skip is pending.
// A skip token of n rows (clamped to the rows left in the track) holds the input
// while the skip counter issues the rest, one empty row per cycle when not stalled.
// Reset clears the token phase, row count, skip counter and both valid bits.
// A stalled output holds the cell and stalls the input only once the input
// register is also full.
module packed_track_cell_decoder_unit import ptcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_track_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_row_index,
    output logic [11:0] o_period,
    output logic [4:0]  o_instrument,
    output logic [3:0]  o_effect,
    output logic [7:0]  o_effect_param,
    output logic        o_last_row,
    output logic        o_bad_note
);

`include "packed_track_cell_decoder_unit_assert.svh"

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_start;

    // decoder state
    t_dec_state       r_state;
    logic [ROW_W-1:0] r_skip_left;

    // cell register
    logic             r_out_valid;
    t_cell            r_cell;

    t_dec_result      dec_res;
    logic             out_free;
    logic             skip_busy;
    logic             in_consume;
    logic             in_take;
    logic             step;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign skip_busy  = (r_skip_left != '0);
    assign in_consume = r_in_valid && out_free && !skip_busy;
    assign step       = out_free && (skip_busy || r_in_valid);
    assign o_in_stall = r_in_valid && !in_consume;
    assign in_take    = i_in_valid && !o_in_stall;

    ptcd_cell_decode u_decode (
        .i_state     (r_state),
        .i_skip_left (r_skip_left),
        .i_drain     (skip_busy),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .o_res       (dec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (in_consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_track_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= PH_IDLE;
            r_state.first_byte  <= '0;
            r_state.second_byte <= '0;
            r_state.row_count   <= '0;
            r_skip_left         <= '0;
        end else if (step) begin
            r_state     <= dec_res.state;
            r_skip_left <= dec_res.skip_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && dec_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && dec_res.emit) begin
            r_cell <= dec_res.row_cell;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_row_index    = r_cell.row_index;
    assign o_period       = r_cell.period;
    assign o_instrument   = r_cell.instrument;
    assign o_effect       = r_cell.effect;
    assign o_effect_param = r_cell.effect_param;
    assign o_last_row     = r_cell.last_row;
    assign o_bad_note     = r_cell.bad_note;

    // A skip run never reaches past the last row of the track.
    `PTCD_ASSERT(a_skip_in_track, !skip_busy || (r_state.row_count < ROWS_VAL),
        "skip past end")
    `PTCD_ASSERT(a_row_bound, r_state.row_count <= ROWS_VAL, "row count out of range")
    // A pending skip row that finds the output free comes out as an empty cell.
    `PTCD_ASSERT_NEXT(a_skip_empty, skip_busy && out_free,
        o_out_valid && (o_period == '0) && (o_instrument == '0) && !o_bad_note,
        "skip row not empty")
    // No byte leaves the input register while a skip run is pending.
    `PTCD_ASSERT_NEXT(a_skip_holds, skip_busy && r_in_valid,
        r_in_valid && $stable(r_in_byte), "byte lost during skip")

endmodule
